### hw/rtl/tle_pkg.sv
// Shared types, constants and sizes for the terminal line editor.
package tle_pkg;

  localparam int LINE_MAX = 32;
  localparam int ADDR_W   = $clog2(LINE_MAX);
  localparam int LEN_W    = $clog2(LINE_MAX + 1);
  localparam int Q_DEPTH  = 4;
  localparam int Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic [1:0] KIND_TERM  = 2'd0;
  localparam logic [1:0] KIND_LINE  = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;
  localparam logic [1:0] KIND_BREAK = 2'd3;

  localparam logic [1:0] ECHO_NONE  = 2'd0;
  localparam logic [1:0] ECHO_TYPED = 2'd1;

  localparam logic REG_ECHO_MODE = 1'b0;
  localparam logic REG_MASK_CHAR = 1'b1;

  localparam logic [1:0] ECHO_MODE_RST = 2'd0;
  localparam logic [7:0] MASK_CHAR_RST = 8'd42;

  localparam logic [7:0] CH_ETX      = 8'h03;
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_C        = 8'h43;
  localparam logic [7:0] CH_D        = 8'h44;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;

  typedef enum logic [1:0] {
    ESC_IDLE,
    ESC_SEEN,
    ESC_BRACKET
  } esc_t;

  typedef enum logic [2:0] {
    OP_ECHO,
    OP_BS2,
    OP_BS3,
    OP_ARROW,
    OP_BREAK,
    OP_LINE
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [7:0]       data;
    logic [LEN_W-1:0] len;
  } cmd_t;

endpackage

### hw/rtl/tle_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/tle_queue.sv
// Small command queue between the byte decoder and the output sequencer.
module tle_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tle_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          head_valid,
  output tle_pkg::cmd_t head_cmd,
  input  logic          pop
);
  import tle_pkg::*;

  cmd_t               slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic               do_push, do_pop;

  assign full       = (count_r == Q_CNT_W'(Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + Q_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### hw/rtl/tle_front.sv
// Byte decoder: tracks line, cursor and escape state and issues output commands.
module tle_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_rx_byte,
  input  logic [1:0]                 echo_mode,
  input  logic [7:0]                 mask_char,
  input  logic                       q_full,
  output logic                       q_push,
  output tle_pkg::cmd_t              q_cmd,
  input  logic                       dump_done,
  output logic                       ram_we,
  output logic [tle_pkg::ADDR_W-1:0] ram_waddr,
  output logic [7:0]                 ram_wdata
);
  import tle_pkg::*;

  esc_t             phase_r, phase_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] cur_r, cur_nxt;
  logic             cur_valid_r, cur_valid_nxt;
  logic             dump_busy_r, dump_busy_nxt;
  logic             accept;
  logic [LEN_W-1:0] cp;
  logic [7:0]       echo_data;
  logic             echo_en;
  logic [7:0]       b;

  assign b         = in_rx_byte;
  assign in_stall  = q_full || dump_busy_r;
  assign accept    = in_valid && !in_stall;
  assign cp        = cur_valid_r ? cur_r : len_r;
  assign echo_en   = (echo_mode != ECHO_NONE);
  assign echo_data = (echo_mode == ECHO_TYPED) ? b : mask_char;
  assign ram_wdata = b;

  always_comb begin
    phase_nxt     = phase_r;
    len_nxt       = len_r;
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    dump_busy_nxt = dump_busy_r && !dump_done;
    q_push        = 1'b0;
    q_cmd.op      = OP_ECHO;
    q_cmd.data    = echo_data;
    q_cmd.len     = len_r;
    ram_we        = 1'b0;
    ram_waddr     = cur_r[ADDR_W-1:0];
    if (accept) begin
      unique case (phase_r)
        ESC_SEEN: begin
          phase_nxt = (b == CH_LBRACKET) ? ESC_BRACKET : ESC_IDLE;
        end
        ESC_BRACKET: begin
          phase_nxt = ESC_IDLE;
          if ((b == CH_D || b == CH_C) && len_r != '0) begin
            cur_valid_nxt = 1'b1;
            cur_nxt       = cp;
            q_cmd.op      = OP_ARROW;
            q_cmd.data    = b;
            if (b == CH_D && cp != '0) begin
              cur_nxt = cp - LEN_W'(1);
              q_push  = 1'b1;
            end else if (b == CH_C && cp < len_r) begin
              cur_nxt = cp + LEN_W'(1);
              q_push  = 1'b1;
            end
          end
        end
        ESC_IDLE: begin
          unique case (b)
            CH_BS: begin
              cur_valid_nxt = 1'b1;
              q_push        = 1'b1;
              if (cp != '0) begin
                cur_nxt  = cp - LEN_W'(1);
                len_nxt  = cp - LEN_W'(1);
                q_cmd.op = (echo_mode == ECHO_NONE) ? OP_BS2 : OP_BS3;
              end else begin
                cur_nxt    = cp;
                q_cmd.op   = OP_ARROW;
                q_cmd.data = CH_C;
              end
            end
            CH_ETX: begin
              q_push        = 1'b1;
              q_cmd.op      = OP_BREAK;
              len_nxt       = '0;
              cur_nxt       = '0;
              cur_valid_nxt = 1'b0;
            end
            CH_LF: begin
              q_push        = 1'b1;
              q_cmd.op      = OP_LINE;
              dump_busy_nxt = 1'b1;
              len_nxt       = '0;
              cur_nxt       = '0;
              cur_valid_nxt = 1'b0;
            end
            CH_CR: begin
            end
            CH_ESC: begin
              phase_nxt = ESC_SEEN;
              q_push    = echo_en;
            end
            default: begin
              if (cur_valid_r && cur_r < len_r) begin
                // Overwrite in place at the cursor.
                ram_we  = 1'b1;
                cur_nxt = cur_r + LEN_W'(1);
                q_push  = echo_en;
              end else if (len_r < LEN_W'(LINE_MAX)) begin
                ram_we        = 1'b1;
                ram_waddr     = len_r[ADDR_W-1:0];
                len_nxt       = len_r + LEN_W'(1);
                cur_nxt       = len_r + LEN_W'(1);
                cur_valid_nxt = 1'b1;
                q_push        = echo_en;
              end
            end
          endcase
        end
        default: begin
          phase_nxt = ESC_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= ESC_IDLE;
      len_r       <= '0;
      cur_r       <= '0;
      cur_valid_r <= 1'b0;
      dump_busy_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      len_r       <= len_nxt;
      cur_r       <= cur_nxt;
      cur_valid_r <= cur_valid_nxt;
      dump_busy_r <= dump_busy_nxt;
    end
  end

endmodule

### hw/rtl/tle_back.sv
// Output sequencer: expands queued commands into result words, one per cycle while out_stall is low.
module tle_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  tle_pkg::cmd_t              q_cmd,
  output logic                       q_pop,
  output logic                       dump_done,
  output logic                       ram_re,
  output logic [tle_pkg::ADDR_W-1:0] ram_raddr,
  input  logic [7:0]                 ram_rdata,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_kind,
  output logic [7:0]                 out_data,
  output logic                       out_last
);
  import tle_pkg::*;

  logic [LEN_W-1:0] idx_r, idx_nxt;
  logic             s1_valid_r, s1_valid_nxt;
  logic [1:0]       s1_kind_r;
  logic [7:0]       s1_data_r;
  logic             s1_last_r;
  logic             s1_ram_r;
  logic             o_valid_r, o_valid_nxt;
  logic [1:0]       o_kind_r;
  logic [7:0]       o_data_r;
  logic             o_last_r;
  logic             out_load, s1_go, issue;
  logic [1:0]       w_kind;
  logic [7:0]       w_data;
  logic             w_last;
  logic             w_ram;

  // Word at position idx_r of the command at the queue head.
  always_comb begin
    w_kind = KIND_TERM;
    w_data = q_cmd.data;
    w_last = 1'b0;
    w_ram  = 1'b0;
    unique case (q_cmd.op)
      OP_ECHO: begin
        w_last = 1'b1;
      end
      OP_BS2: begin
        w_data = (idx_r == '0) ? CH_SPACE : CH_BS;
        w_last = (idx_r != '0);
      end
      OP_BS3: begin
        w_data = (idx_r == LEN_W'(1)) ? CH_SPACE : CH_BS;
        w_last = (idx_r == LEN_W'(2));
      end
      OP_ARROW: begin
        if (idx_r == '0) begin
          w_data = CH_ESC;
        end else if (idx_r == LEN_W'(1)) begin
          w_data = CH_LBRACKET;
        end
        w_last = (idx_r == LEN_W'(2));
      end
      OP_BREAK: begin
        w_kind = KIND_BREAK;
        w_data = '0;
        w_last = 1'b1;
      end
      OP_LINE: begin
        if (idx_r < q_cmd.len) begin
          w_kind = KIND_LINE;
          w_ram  = 1'b1;
        end else begin
          w_kind = KIND_END;
          w_data = '0;
          w_last = 1'b1;
        end
      end
      default: begin
        w_last = 1'b1;
      end
    endcase
  end

  assign out_load  = !o_valid_r || !out_stall;
  assign s1_go     = !s1_valid_r || out_load;
  assign issue     = s1_go && q_valid;
  assign q_pop     = issue && w_last;
  assign dump_done = issue && w_last && (q_cmd.op == OP_LINE);
  assign ram_re    = issue && w_ram;
  assign ram_raddr = idx_r[ADDR_W-1:0];

  assign out_valid = o_valid_r;
  assign out_kind  = o_kind_r;
  assign out_data  = o_data_r;
  assign out_last  = o_last_r;

  always_comb begin
    idx_nxt      = idx_r;
    s1_valid_nxt = s1_valid_r;
    o_valid_nxt  = o_valid_r;
    if (issue) begin
      idx_nxt = w_last ? '0 : idx_r + LEN_W'(1);
    end
    if (s1_go) begin
      s1_valid_nxt = issue;
    end
    if (out_load) begin
      o_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      s1_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
    end else begin
      idx_r      <= idx_nxt;
      s1_valid_r <= s1_valid_nxt;
      o_valid_r  <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_kind_r <= w_kind;
      s1_data_r <= w_data;
      s1_last_r <= w_last;
      s1_ram_r  <= w_ram;
    end
    if (out_load && s1_valid_r) begin
      o_kind_r <= s1_kind_r;
      o_data_r <= s1_ram_r ? ram_rdata : s1_data_r;
      o_last_r <= s1_last_r;
    end
  end

endmodule

### hw/rtl/terminal_line_editor_core.sv
// Top level of the terminal line editor: config registers, decoder, queue, sequencer.
// The first result word of a byte is registered in a queue slot, then in s1, then in the output register.
// Throughput: one byte per cycle while the four-entry command queue has room and no line feed is pending;
// results leave at one word per cycle while out_stall is low; a multi-word echo holds the queue head.
// A line feed blocks input until its end marker has been issued from the queue head.
// Reset clears line, cursor, escape state and queue, and restores echo_mode 0, mask 42.
module terminal_line_editor_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_data,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tle_pkg::*;

  logic [1:0]        echo_mode_r;
  logic [7:0]        mask_char_r;
  logic              cfg_write;
  logic              q_full, q_push, q_valid, q_pop;
  cmd_t              q_push_cmd, q_head_cmd;
  logic              dump_done;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == REG_MASK_CHAR) ? {24'd0, mask_char_r} : {30'd0, echo_mode_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_mode_r <= ECHO_MODE_RST;
      mask_char_r <= MASK_CHAR_RST;
    end else if (cfg_write) begin
      if (paddr[2] == REG_ECHO_MODE) begin
        echo_mode_r <= pwdata[1:0];
      end else begin
        mask_char_r <= pwdata[7:0];
      end
    end
  end

  tle_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_rx_byte(in_rx_byte),
    .echo_mode (echo_mode_r),
    .mask_char (mask_char_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_push_cmd),
    .dump_done (dump_done),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  tle_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_push_cmd),
    .full      (q_full),
    .head_valid(q_valid),
    .head_cmd  (q_head_cmd),
    .pop       (q_pop)
  );

  tle_ram #(
    .WIDTH(8),
    .DEPTH(LINE_MAX)
  ) u_line_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  tle_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_cmd    (q_head_cmd),
    .q_pop    (q_pop),
    .dump_done(dump_done),
    .ram_re   (ram_re),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind (out_kind),
    .out_data (out_data),
    .out_last (out_last)
  );

endmodule
